### rtl/assert_macros.svh
// Assertion macros for the checker file of the lookup core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is off while reset is held.
`define ASRL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked during reset too.
`define ASRL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/asrl_pkg.sv
// Shared widths, result codes and controller/datapath interface types.
package asrl_pkg;

    localparam int ADDR_W    = 64;
    localparam int NAME_W    = 24;
    localparam int ENTRY_W   = ADDR_W + NAME_W;
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 152;

    // Result codes carried on m_tuser
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_HIT      = 2'd2,
        ST_MISS     = 2'd3
    } status_t;

    // Read address source for the entry RAM
    typedef enum logic [1:0] {
        RD_MID,
        RD_FLOOR,
        RD_SHIFT
    } rd_sel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    load_item;
        rd_sel_t rd_sel;
        logic    search_upd;
        logic    shift_en;
        logic    ins_commit;
        logic    lookup_res;
        logic    stage_code;
        status_t code;
        logic    out_load;
    } asrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic is_lookup;
        logic full;
        logic below_base;
        logic search_done;
        logic lo_zero;
        logic shift_last;
        logic out_free;
    } asrl_stat_t;

endpackage

### rtl/asrl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module asrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/asrl_datapath.sv
// Datapath: entry RAM, search bounds, insert shifter, result staging and output register.
module asrl_datapath
    import asrl_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [ADDR_W-1:0]    cfg_wdata,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  asrl_cmd_t            cmd,
    output asrl_stat_t           stat,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [1:0]           m_tuser
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Control state
    logic [ADDR_W-1:0] base_reg;
    logic [CW-1:0]     count_reg;
    logic              pend_reg;
    logic              m_valid_reg;

    // Item and search state
    logic              action_reg;
    logic              below_reg;
    logic [ADDR_W-1:0] key_reg;
    logic [NAME_W-1:0] name_in_reg;
    logic [CW-1:0]     lo_reg;
    logic [CW-1:0]     hi_reg;
    logic [CW-1:0]     sp_reg;
    logic [AW-1:0]     wa_reg;

    // Staged result and output beat
    status_t           res_status_reg;
    logic [ADDR_W-1:0] res_start_reg;
    logic [ADDR_W-1:0] res_off_reg;
    logic [NAME_W-1:0] res_name_reg;
    status_t           m_status_reg;
    logic [ADDR_W-1:0] m_start_reg;
    logic [ADDR_W-1:0] m_off_reg;
    logic [NAME_W-1:0] m_name_reg;

    logic [ADDR_W-1:0]  s_addr;
    logic [NAME_W-1:0]  s_name;
    logic [CW-1:0]      mid;
    logic [CW-1:0]      lo_m1;
    logic [CW-1:0]      sp_m1;
    logic               sp_more;
    logic [AW-1:0]      ram_raddr;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               ram_we;
    logic [ADDR_W-1:0]  rd_start;
    logic [NAME_W-1:0]  rd_name;

    assign s_addr   = s_tdata[ADDR_W-1:0];
    assign s_name   = s_tdata[ENTRY_W-1:ADDR_W];
    assign rd_start = ram_rdata[ADDR_W-1:0];
    assign rd_name  = ram_rdata[ENTRY_W-1:ADDR_W];

    // Search midpoint and pointer arithmetic
    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign lo_m1   = lo_reg - CW'(1);
    assign sp_m1   = sp_reg - CW'(1);
    assign sp_more = (sp_reg > lo_reg);

    // RAM read address select
    always_comb begin
        unique case (cmd.rd_sel)
            RD_MID:   ram_raddr = mid[AW-1:0];
            RD_FLOOR: ram_raddr = lo_m1[AW-1:0];
            RD_SHIFT: ram_raddr = sp_m1[AW-1:0];
            default:  ram_raddr = mid[AW-1:0];
        endcase
    end

    // RAM write: new entry on commit, else the pending shifted entry
    assign ram_we    = cmd.ins_commit | pend_reg;
    assign ram_waddr = cmd.ins_commit ? lo_reg[AW-1:0] : wa_reg;
    assign ram_wdata = cmd.ins_commit ? {name_in_reg, key_reg} : ram_rdata;

    asrl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg    <= '0;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                base_reg <= cfg_wdata;
            end
            if (cmd.ins_commit) begin
                count_reg <= count_reg + CW'(1);
            end
            pend_reg <= cmd.shift_en & sp_more;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Item capture, search bounds and shift pointer
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            action_reg  <= s_tuser;
            key_reg     <= s_tuser ? (s_addr - base_reg) : s_addr;
            below_reg   <= s_tuser & (s_addr < base_reg);
            name_in_reg <= s_name;
            lo_reg      <= '0;
            hi_reg      <= count_reg;
            sp_reg      <= count_reg;
        end
        if (cmd.search_upd) begin
            if (rd_start <= key_reg) begin
                lo_reg <= mid + CW'(1);
            end else begin
                hi_reg <= mid;
            end
        end
        if (cmd.shift_en && sp_more) begin
            sp_reg <= sp_m1;
            wa_reg <= sp_reg[AW-1:0];
        end
    end

    // Result staging and output beat
    always_ff @(posedge aclk) begin
        if (cmd.lookup_res) begin
            res_status_reg <= ST_HIT;
            res_start_reg  <= base_reg + rd_start;
            res_off_reg    <= key_reg - rd_start;
            res_name_reg   <= rd_name;
        end else if (cmd.stage_code) begin
            res_status_reg <= cmd.code;
            res_start_reg  <= '0;
            res_off_reg    <= '0;
            res_name_reg   <= '0;
        end
        if (cmd.out_load) begin
            m_status_reg <= res_status_reg;
            m_start_reg  <= res_start_reg;
            m_off_reg    <= res_off_reg;
            m_name_reg   <= res_name_reg;
        end
    end

    // Status back to the controller
    assign stat.is_lookup   = action_reg;
    assign stat.full        = (count_reg == CW'(TABLE_DEPTH));
    assign stat.below_base  = below_reg;
    assign stat.search_done = (lo_reg == hi_reg);
    assign stat.lo_zero     = (lo_reg == '0);
    assign stat.shift_last  = !sp_more && !pend_reg;
    assign stat.out_free    = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_name_reg, m_off_reg, m_start_reg};
    assign m_tuser  = m_status_reg;

endmodule

### rtl/asrl_ctrl.sv
// Controller: sequences check, binary search, insert shift and result hand-off.
module asrl_ctrl
    import asrl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  asrl_stat_t stat,
    output asrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_FLOOR_WAIT,
        S_SHIFT,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_MID;
        cmd.code   = ST_INSERTED;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (!stat.is_lookup && stat.full) begin
                    cmd.stage_code = 1'b1;
                    cmd.code       = ST_FULL;
                    state_next     = S_OUT;
                end else if (stat.is_lookup && stat.below_base) begin
                    cmd.stage_code = 1'b1;
                    cmd.code       = ST_MISS;
                    state_next     = S_OUT;
                end else begin
                    state_next = S_SEARCH_RD;
                end
            end
            S_SEARCH_RD: begin
                priority if (!stat.search_done) begin
                    cmd.rd_sel = RD_MID;
                    state_next = S_SEARCH_CMP;
                end else if (!stat.is_lookup) begin
                    state_next = S_SHIFT;
                end else if (stat.lo_zero) begin
                    cmd.stage_code = 1'b1;
                    cmd.code       = ST_MISS;
                    state_next     = S_OUT;
                end else begin
                    cmd.rd_sel = RD_FLOOR;
                    state_next = S_FLOOR_WAIT;
                end
            end
            S_SEARCH_CMP: begin
                cmd.search_upd = 1'b1;
                state_next     = S_SEARCH_RD;
            end
            S_FLOOR_WAIT: begin
                cmd.lookup_res = 1'b1;
                state_next     = S_OUT;
            end
            S_SHIFT: begin
                cmd.rd_sel = RD_SHIFT;
                if (stat.shift_last) begin
                    cmd.ins_commit = 1'b1;
                    cmd.stage_code = 1'b1;
                    cmd.code       = ST_INSERTED;
                    state_next     = S_OUT;
                end else begin
                    cmd.shift_en = 1'b1;
                end
            end
            S_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

### rtl/address_to_symbol_range_lookup_core.sv
// Top level of the sorted address table with floor lookup.
// Keeps up to TABLE_DEPTH (start, name) entries sorted by start in one RAM with a
// single read and a single write port. An insert beat (s_tuser = 0) places the entry
// after all entries with an equal or lower start; when the table is full it answers
// "full" and changes nothing. A lookup beat (s_tuser = 1) subtracts the base register
// and returns the last entry at or below the result, or a miss. Every beat gives one
// result beat. One item is worked at a time: a lookup runs the binary search and then
// reads the floor entry; an insert runs the same search and then moves every entry
// above the insert point up by one. The RAM read port sets the pace: each search step
// is a registered read then a compare, and the shift moves one entry a cycle. A new
// item is taken while the previous result still waits on m_tready.
// Write cfg_wdata only while the core is idle.
module address_to_symbol_range_lookup_core
    import asrl_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Base register write
    input  logic                 cfg_we,
    input  logic [ADDR_W-1:0]    cfg_wdata,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // address[63:0], name_ref[87:64]
    input  logic                 s_tuser,   // action
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // start_address[63:0], offset_within[127:64],
                                            // found_name_ref[151:128]
    output logic [1:0]           m_tuser    // status
);

    asrl_cmd_t  cmd;
    asrl_stat_t stat;

    asrl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    asrl_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

### rtl/asrl_checker.sv
// Port-level checker for the lookup core and its bind.
`include "assert_macros.svh"

module asrl_checker
    import asrl_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [1:0]           m_tuser
);

    // No result beat right after reset
    `ASRL_ASSERT_ALWAYS(a_no_beat_after_reset, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // A stalled result beat holds
    `ASRL_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // Only hits carry data
    `ASRL_ASSERT(a_nohit_zero, aclk, aresetn, m_tvalid && (m_tuser != ST_HIT) |-> (m_tdata == '0), "non-hit result carries data")

    // One item at a time: ready drops after an accepted beat
    `ASRL_ASSERT(a_one_item, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "second beat taken while busy")

endmodule

bind address_to_symbol_range_lookup_core asrl_checker u_asrl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
